// ===== sv/periodic_stream_action_scheduler_defines.svh =====
// Assertion macros for the periodic stream action scheduler.
// Included by the RTL modules that carry concurrent checks; needs a clk and rst in scope.
`ifndef PERIODIC_STREAM_ACTION_SCHEDULER_DEFINES_SVH
`define PERIODIC_STREAM_ACTION_SCHEDULER_DEFINES_SVH

// Check that holds on the same edge.
`define PSAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check whose consequent holds on the edge after the antecedent.
`define PSAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/psas_pkg.sv =====
// Shared types and constants for the periodic stream action scheduler.
// No dependencies; used by psas_addsub, psas_div and the top level.
package psas_pkg;

  localparam int TICK_W      = 32;
  localparam int RATE_W      = 16;
  localparam int ID_W        = 8;
  localparam int MASK_W      = 6;
  localparam int MAP_ENTRIES = 6;
  localparam int MAP_W       = 48;
  localparam int DATA_W      = 64;
  localparam int ADDR_W      = 4;

  localparam logic [MAP_W-1:0] MAP_RESET = 48'd12103319159552;

  // Register index taken from the byte address.
  localparam logic REG_STREAM_MAP = 1'b0;

  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_REQ,
    ST_DUE,
    ST_CMP,
    ST_NXT,
    ST_CND,
    ST_MIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              sub;
    logic [TICK_W-1:0] a;
    logic [TICK_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [TICK_W-1:0] res;
    logic              borrow;
    logic              zero;
  } alu_rsp_t;

endpackage

// ===== sv/psas_addsub.sv =====
// Shared 32-bit add/subtract unit with borrow and zero flags.
// Depends on psas_pkg for the request and response structs.
module psas_addsub (
  input  psas_pkg::alu_req_t req,
  output psas_pkg::alu_rsp_t rsp
);

  logic [psas_pkg::TICK_W:0] sum;

  always_comb begin
    if (req.sub) begin
      sum = {1'b0, req.a} + {1'b0, ~req.b} + {{psas_pkg::TICK_W{1'b0}}, 1'b1};
    end else begin
      sum = {1'b0, req.a} + {1'b0, req.b};
    end
    rsp.res    = sum[psas_pkg::TICK_W-1:0];
    // For a subtraction a missing carry out means a < b.
    rsp.borrow = req.sub & ~sum[psas_pkg::TICK_W];
    rsp.zero   = (sum[psas_pkg::TICK_W-1:0] == '0);
  end

endmodule

// ===== sv/psas_div.sv =====
// Restoring divider, one quotient bit per cycle, for the tick period of a rate.
// Depends on psas_pkg for the rate width.
module psas_div #(
  parameter int QW = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [QW-1:0]               dividend,
  input  logic [psas_pkg::RATE_W-1:0] divisor,
  output logic                        done,
  output logic [QW-1:0]               quotient
);

  localparam int CW = $clog2(QW + 1);

  logic                        busy;
  logic [CW-1:0]               cnt;
  logic [psas_pkg::RATE_W-1:0] rem;
  logic [psas_pkg::RATE_W-1:0] dsr;
  logic [QW-1:0]               quo;
  logic [psas_pkg::RATE_W:0]   trial;
  logic                        fits;
  logic [QW:0]                 quo_shift;

  always_comb begin
    trial     = {rem, quo[QW-1]};
    fits      = (trial >= {1'b0, dsr});
    quo_shift = {quo, fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // The dividend shifts out of the top of quo while quotient bits enter below.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= quo_shift[QW-1:0];
      if (fits) begin
        rem <= psas_pkg::RATE_W'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[psas_pkg::RATE_W-1:0];
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== sv/periodic_stream_action_scheduler.sv =====
// Periodic stream action scheduler: a sequencer stepping one add/subtract unit over the table.
// Tick beat: a disabled entry takes ST_DUE alone, an enabled entry that waits takes ST_DUE,
// ST_CMP and ST_MIN, and one that fires takes ST_NXT and ST_CND as well; ST_OUT then loads
// the output register, longer while out_stall holds, and in_stall holds until ST_IDLE again.
// Rate request beat: ST_DIV runs the divider before ST_REQ; a disable or a zero rate goes to ST_REQ.
// Synchronous active-high reset: entry zero enabled at rate 1, stream map at its default.
module periodic_stream_action_scheduler #(
  parameter int NUM_ENTRIES      = 6,
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [psas_pkg::TICK_W-1:0]   now,
  input  logic [psas_pkg::ID_W-1:0]     stream_id,
  input  logic                          enable,
  input  logic [psas_pkg::RATE_W-1:0]   rate_hz,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [psas_pkg::MASK_W-1:0]   fired_mask,
  output logic [psas_pkg::TICK_W-1:0]   next_delay,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psas_pkg::ADDR_W-1:0]   paddr,
  input  logic [psas_pkg::DATA_W-1:0]   pwdata,
  output logic [psas_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

`include "periodic_stream_action_scheduler_defines.svh"

  localparam int QW = $clog2(TICKS_PER_SECOND + 1);
  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int TW = psas_pkg::TICK_W;

  psas_pkg::state_t state, state_next;

  logic [psas_pkg::MAP_W-1:0] stream_map;

  logic                 entry_en     [NUM_ENTRIES];
  logic [QW-1:0]        entry_period [NUM_ENTRIES];
  logic [TW-1:0]        entry_last   [NUM_ENTRIES];

  logic [IW-1:0]               idx;
  logic [TW-1:0]               now_r;
  logic [TW-1:0]               due_r;
  logic [TW-1:0]               cand_r;
  logic [TW-1:0]               best_r;
  logic [psas_pkg::MASK_W-1:0] mask_r;
  logic [psas_pkg::ID_W-1:0]   req_sid;
  logic                        req_on;

  logic                 in_accept;
  logic                 out_free;
  logic                 out_load;
  logic                 last_entry;
  logic                 fire;
  logic [TW-1:0]        period_ext;
  logic [NUM_ENTRIES-1:0] hit;

  psas_pkg::alu_req_t alu_req;
  psas_pkg::alu_rsp_t alu_rsp;

  logic          div_start;
  logic          div_done;
  logic [QW-1:0] div_quo;

  psas_addsub u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  psas_div #(
    .QW (QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (QW'(TICKS_PER_SECOND)),
    .divisor  (rate_hz),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign out_load   = (state == psas_pkg::ST_OUT) && out_free;
  assign last_entry = (idx == IW'(NUM_ENTRIES - 1));
  assign period_ext = {{(TW - QW){1'b0}}, entry_period[idx]};
  // Due tick at or before now.
  assign fire       = alu_rsp.borrow || alu_rsp.zero;

  // Entries past the stream map have stream id zero and never match a request.
  always_comb begin
    logic [psas_pkg::ID_W-1:0] sid;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      sid = '0;
      if (i < psas_pkg::MAP_ENTRIES) begin
        sid = stream_map[psas_pkg::ID_W*i +: psas_pkg::ID_W];
      end
      hit[i] = (req_sid == '0) ? (sid != '0) : (sid == req_sid);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      psas_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (kind == psas_pkg::KIND_REQUEST) begin
            state_next = (enable && rate_hz != '0) ? psas_pkg::ST_DIV : psas_pkg::ST_REQ;
          end else begin
            state_next = psas_pkg::ST_DUE;
          end
        end
      end
      psas_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = psas_pkg::ST_REQ;
        end
      end
      psas_pkg::ST_REQ: state_next = psas_pkg::ST_IDLE;
      psas_pkg::ST_DUE: begin
        if (entry_en[idx]) begin
          state_next = psas_pkg::ST_CMP;
        end else if (last_entry) begin
          state_next = psas_pkg::ST_OUT;
        end
      end
      psas_pkg::ST_CMP: state_next = fire ? psas_pkg::ST_NXT : psas_pkg::ST_MIN;
      psas_pkg::ST_NXT: state_next = psas_pkg::ST_CND;
      psas_pkg::ST_CND: state_next = psas_pkg::ST_MIN;
      psas_pkg::ST_MIN: state_next = last_entry ? psas_pkg::ST_OUT : psas_pkg::ST_DUE;
      psas_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = psas_pkg::ST_IDLE;
        end
      end
      default: state_next = psas_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: stall, divider start and the operands of the shared unit.
  always_comb begin
    in_stall    = (state != psas_pkg::ST_IDLE);
    div_start   = 1'b0;
    alu_req.sub = 1'b0;
    alu_req.a   = '0;
    alu_req.b   = '0;
    unique case (state)
      psas_pkg::ST_IDLE: begin
        div_start = in_valid && (kind == psas_pkg::KIND_REQUEST) && enable && (rate_hz != '0);
      end
      psas_pkg::ST_DUE: begin
        alu_req.a = entry_last[idx];
        alu_req.b = period_ext;
      end
      psas_pkg::ST_CMP: begin
        alu_req.sub = 1'b1;
        alu_req.a   = due_r;
        alu_req.b   = now_r;
      end
      psas_pkg::ST_NXT: begin
        alu_req.a = due_r;
        alu_req.b = period_ext;
      end
      psas_pkg::ST_CND: begin
        alu_req.sub = 1'b1;
        alu_req.a   = due_r;
        alu_req.b   = now_r;
      end
      psas_pkg::ST_MIN: begin
        alu_req.sub = 1'b1;
        alu_req.a   = cand_r;
        alu_req.b   = best_r;
      end
      default: begin
        alu_req.sub = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psas_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers of the scan and of request latching.
  always_ff @(posedge clk) begin
    if (state == psas_pkg::ST_IDLE && in_accept) begin
      now_r   <= now;
      req_sid <= stream_id;
      req_on  <= enable && (rate_hz != '0);
      idx     <= '0;
      best_r  <= '1;
      mask_r  <= '0;
    end
    if ((state == psas_pkg::ST_DUE && !entry_en[idx]) || state == psas_pkg::ST_MIN) begin
      idx <= idx + IW'(1);
    end
    if (state == psas_pkg::ST_DUE || state == psas_pkg::ST_NXT) begin
      due_r <= alu_rsp.res;
    end
    if (state == psas_pkg::ST_CMP && !fire) begin
      cand_r <= alu_rsp.res;
    end
    if (state == psas_pkg::ST_CMP && fire && (32'(idx) < psas_pkg::MAP_ENTRIES)) begin
      mask_r <= mask_r | (psas_pkg::MASK_W'(1) << idx);
    end
    // Next due tick strictly after now gives its distance, otherwise zero.
    if (state == psas_pkg::ST_CND) begin
      cand_r <= (!alu_rsp.borrow && !alu_rsp.zero) ? alu_rsp.res : '0;
    end
    if (state == psas_pkg::ST_MIN && alu_rsp.borrow) begin
      best_r <= cand_r;
    end
  end

  // Entry table.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        entry_en[i]     <= (i == 0);
        entry_period[i] <= (i == 0) ? QW'(TICKS_PER_SECOND) : '0;
        entry_last[i]   <= '0;
      end
    end else begin
      if (state == psas_pkg::ST_REQ) begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (hit[i]) begin
            entry_en[i] <= req_on;
            if (req_on) begin
              entry_period[i] <= div_quo;
            end
          end
        end
      end
      if (state == psas_pkg::ST_CMP && fire) begin
        entry_last[idx] <= now_r;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == psas_pkg::ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == psas_pkg::ST_OUT && out_free) begin
      fired_mask <= mask_r;
      next_delay <= best_r;
    end
  end

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_map <= psas_pkg::MAP_RESET;
    end else if (psel && penable && pwrite && (paddr[3] == psas_pkg::REG_STREAM_MAP)) begin
      stream_map <= pwdata[psas_pkg::MAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[3] == psas_pkg::REG_STREAM_MAP) begin
      prdata = {{(psas_pkg::DATA_W - psas_pkg::MAP_W){1'b0}}, stream_map};
    end
  end

  `PSAS_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall, "accepted beat left input open")
  `PSAS_ASSERT_NEXT(a_result_from_out, !out_valid && !out_load, !out_valid, "stray result")
  `PSAS_ASSERT(a_fire_delay, !out_valid || fired_mask == '0 || next_delay != '1, "no next delay")
  `PSAS_ASSERT(a_div_done_in_div, !div_done || (state == psas_pkg::ST_DIV), "stray divider done")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for periodic_stream_action_scheduler: directed table, then random
// phases under several stream maps and handshake idling patterns. Needs psas_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ENTRIES      = 6;
  localparam int TICKS_PER_SECOND = 1000;
  localparam int NUM_PHASES       = 8;
  localparam int ITEMS_PER_PHASE  = 216;
  localparam int SETTLE_CYCLES    = 40;
  localparam int MAX_GAP          = 12;
  localparam int MAX_MISMATCH_LOG = 10;
  localparam int CYCLE_LIMIT      = 1000000;
  localparam logic [psas_pkg::ADDR_W-1:0] STREAM_MAP_ADDR =
    psas_pkg::ADDR_W'(8 * psas_pkg::REG_STREAM_MAP);

  typedef struct packed {
    logic                        kind;
    logic [psas_pkg::TICK_W-1:0] now;
    logic [psas_pkg::ID_W-1:0]   sid;
    logic                        en;
    logic [psas_pkg::RATE_W-1:0] rate;
  } beat_t;

  typedef struct packed {
    logic [psas_pkg::MASK_W-1:0] mask;
    logic [psas_pkg::TICK_W-1:0] delay;
  } tick_report_t;

  typedef struct {
    beat_t        b;
    bit           known;
    tick_report_t rep;
  } directed_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          kind = psas_pkg::KIND_TICK;
  logic [psas_pkg::TICK_W-1:0]   now = '0;
  logic [psas_pkg::ID_W-1:0]     stream_id = '0;
  logic                          enable = 1'b0;
  logic [psas_pkg::RATE_W-1:0]   rate_hz = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [psas_pkg::MASK_W-1:0]   fired_mask;
  logic [psas_pkg::TICK_W-1:0]   next_delay;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [psas_pkg::ADDR_W-1:0]   paddr = '0;
  logic [psas_pkg::DATA_W-1:0]   pwdata = '0;
  logic [psas_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  periodic_stream_action_scheduler #(
    .NUM_ENTRIES     (NUM_ENTRIES),
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_dut (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Shadow copy of the action table and the stream map.
  logic [psas_pkg::MAP_W-1:0]  model_map;
  logic [psas_pkg::RATE_W-1:0] model_rate [NUM_ENTRIES];
  logic [psas_pkg::TICK_W-1:0] model_last [NUM_ENTRIES];

  tick_report_t pending_reports[$];
  directed_row_t directed_rows[$];

  int idle_pct_in;
  int stall_pct_out;
  int sender_calm;
  logic [psas_pkg::TICK_W-1:0] wall_ms;
  int mismatch_count;
  int cycle_count;
  int n_ticks, n_requests, n_reports, n_fires, n_none_enabled;

  function automatic bit advance_schedule(input beat_t b, output tick_report_t rep);
    logic [psas_pkg::ID_W-1:0]   entry_sid;
    logic [psas_pkg::TICK_W-1:0] period, due, nxt, cand, best;
    logic [psas_pkg::MASK_W-1:0] mask;
    bit                          hit;
    rep = '0;
    if (b.kind == psas_pkg::KIND_REQUEST) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        entry_sid = (i < psas_pkg::MAP_ENTRIES) ? model_map[8*i +: 8] : '0;
        hit = (b.sid == '0) ? (entry_sid != '0) : (entry_sid == b.sid);
        if (hit) model_rate[i] = b.en ? b.rate : '0;
      end
      return 1'b0;
    end
    best = '1;
    mask = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (model_rate[i] != '0) begin
        period = TICKS_PER_SECOND / model_rate[i];
        due = model_last[i] + period;
        // Plain unsigned compares: a wrapped due tick looks early and fires at once.
        if (b.now >= due) begin
          nxt = due + period;
          model_last[i] = b.now;
          if (i < psas_pkg::MASK_W) mask[i] = 1'b1;
          cand = (nxt > b.now) ? nxt - b.now : '0;
        end else begin
          cand = due - b.now;
        end
        if (cand < best) best = cand;
      end
    end
    rep.mask = mask;
    rep.delay = best;
    return 1'b1;
  endfunction

  function automatic directed_row_t mk_row(input logic k, input logic [psas_pkg::TICK_W-1:0] t,
                                           input logic [psas_pkg::ID_W-1:0] s, input logic e,
                                           input logic [psas_pkg::RATE_W-1:0] r, input bit known,
                                           input logic [psas_pkg::MASK_W-1:0] m,
                                           input logic [psas_pkg::TICK_W-1:0] d);
    directed_row_t row;
    row.b = '{kind: k, now: t, sid: s, en: e, rate: r};
    row.known = known;
    row.rep = '{mask: m, delay: d};
    return row;
  endfunction

  function automatic beat_t next_random_beat();
    beat_t b;
    int pick;
    b = '{kind: psas_pkg::KIND_TICK, now: $urandom, sid: psas_pkg::ID_W'($urandom),
          en: 1'($urandom), rate: psas_pkg::RATE_W'($urandom)};
    pick = $urandom_range(99);
    if (pick < 22) begin
      b.kind = psas_pkg::KIND_REQUEST;
      pick = $urandom_range(99);
      if (pick < 55) b.sid = model_map[8*$urandom_range(psas_pkg::MAP_ENTRIES-1) +: 8];
      else if (pick < 70) b.sid = '0;
      b.en = ($urandom_range(99) < 80);
      pick = $urandom_range(99);
      if (pick < 45) b.rate = psas_pkg::RATE_W'($urandom_range(50, 1));
      else if (pick < 70) b.rate = psas_pkg::RATE_W'($urandom_range(TICKS_PER_SECOND, 1));
      else if (pick < 80)
        b.rate = psas_pkg::RATE_W'($urandom_range(65535, TICKS_PER_SECOND + 1));
      else if (pick < 90) b.rate = '0;
    end else begin
      pick = $urandom_range(99);
      if (pick < 85) wall_ms = wall_ms + $urandom_range(300);
      else if (pick < 95) wall_ms = $urandom;
      else wall_ms = '1 - $urandom_range(500);
      b.now = wall_ms;
    end
    return b;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_MISMATCH_LOG) $display("mismatch: %s", msg);
  endtask

  // One input beat: optional idle gap, then hold until the scheduler takes it.
  task automatic drive_beat(input beat_t b, input bit use_known, input tick_report_t known_rep);
    int gap;
    tick_report_t rep;
    gap = 0;
    if (sender_calm > 0) begin
      sender_calm--;
    end else begin
      if ($urandom_range(31) == 0) sender_calm = $urandom_range(30, 8);
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct_in) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= b.kind;
    now       <= b.now;
    stream_id <= b.sid;
    enable    <= b.en;
    rate_hz   <= b.rate;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (b.kind == psas_pkg::KIND_REQUEST) n_requests++;
    else n_ticks++;
    if (advance_schedule(b, rep)) pending_reports.push_back(use_known ? known_rep : rep);
  endtask

  // Setup and access cycles, then the bus goes back to idle.
  task automatic apb_access(input bit wr, input logic [psas_pkg::DATA_W-1:0] wdata,
                            output logic [psas_pkg::DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= STREAM_MAP_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_map_readback();
    logic [psas_pkg::DATA_W-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd[psas_pkg::MAP_W-1:0] !== model_map)
      note_mismatch($sformatf("stream_map read expected %h got %h", model_map,
                              rd[psas_pkg::MAP_W-1:0]));
  endtask

  // A rate request leaves no report behind, so allow its processing time after the drain.
  task automatic drain_and_settle();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Report checker and receiver stall generator.
  int stall_run;
  int recv_calm;
  always @(posedge clk) begin
    tick_report_t exp_rep;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        note_mismatch($sformatf("report with nothing expected: mask %b delay %0d",
                                fired_mask, next_delay));
      end else begin
        exp_rep = pending_reports.pop_front();
        n_reports++;
        n_fires += $countones(fired_mask);
        if (next_delay == '1) n_none_enabled++;
        if (fired_mask !== exp_rep.mask)
          note_mismatch($sformatf("fired_mask expected %b got %b", exp_rep.mask, fired_mask));
        if (next_delay !== exp_rep.delay)
          note_mismatch($sformatf("next_delay expected %0d got %0d",
                                  exp_rep.delay, next_delay));
      end
    end
    if (rst) begin
      out_stall <= 1'b0;
      stall_run = 0;
      recv_calm = 0;
    end else if (recv_calm > 0) begin
      recv_calm--;
      out_stall <= 1'b0;
      stall_run = 0;
    end else if (stall_run < MAX_GAP && $urandom_range(99) < stall_pct_out) begin
      out_stall <= 1'b1;
      stall_run++;
    end else begin
      out_stall <= 1'b0;
      stall_run = 0;
      if ($urandom_range(63) == 0) recv_calm = $urandom_range(60, 15);
    end
  end

  initial begin
    logic [psas_pkg::DATA_W-1:0] map_word;
    logic [psas_pkg::DATA_W-1:0] rd;
    tick_report_t no_rep;
    no_rep = '0;
    model_map = psas_pkg::MAP_RESET;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      model_rate[i] = '0;
      model_last[i] = '0;
    end
    model_rate[0] = psas_pkg::RATE_W'(1);
    wall_ms = '0;
    idle_pct_in = 0;
    stall_pct_out = 0;
    sender_calm = 0;

    // Reset map: entries 0..5 carry streams 0, 3, 10, 6, 2, 11; only entry zero runs, at 1 Hz.
    directed_rows.push_back(mk_row(psas_pkg::KIND_TICK, 0, 0, 0, 0, 1, 6'b000000, 1000));
    directed_rows.push_back(mk_row(psas_pkg::KIND_TICK, 999, 0, 0, 0, 1, 6'b000000, 1));
    directed_rows.push_back(mk_row(psas_pkg::KIND_TICK, 1000, 0, 0, 0, 1, 6'b000001, 1000));
    directed_rows.push_back(mk_row(psas_pkg::KIND_REQUEST, 32'hFFFF_FFFF, 3, 1, 10, 0, 0, 0));
    // Stream zero reaches every streamed entry; a rate above the tick rate gives period zero.
    directed_rows.push_back(mk_row(psas_pkg::KIND_REQUEST, 0, 0, 1, 1001, 0, 0, 0));
    directed_rows.push_back(mk_row(psas_pkg::KIND_TICK, 1000, 8'hFF, 1, 16'hFFFF, 0, 0, 0));
    directed_rows.push_back(mk_row(psas_pkg::KIND_REQUEST, 0, 10, 1, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(psas_pkg::KIND_REQUEST, 0, 6, 0, 16'hFFFF, 0, 0, 0));
    directed_rows.push_back(mk_row(psas_pkg::KIND_REQUEST, 0, 2, 1, 16'hFFFF, 0, 0, 0));
    directed_rows.push_back(mk_row(psas_pkg::KIND_REQUEST, 0, 11, 1, 1000, 0, 0, 0));
    directed_rows.push_back(mk_row(psas_pkg::KIND_REQUEST, 0, 8'hFF, 1, 7, 0, 0, 0));
    directed_rows.push_back(mk_row(psas_pkg::KIND_REQUEST, 0, 3, 1, 3, 0, 0, 0));
    directed_rows.push_back(mk_row(psas_pkg::KIND_TICK, 1500, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(psas_pkg::KIND_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
    // Due ticks now wrap past zero and read as already due.
    directed_rows.push_back(mk_row(psas_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(psas_pkg::KIND_TICK, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(psas_pkg::KIND_TICK, 1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(psas_pkg::KIND_REQUEST, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(psas_pkg::KIND_TICK, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(psas_pkg::KIND_REQUEST, 0, 0, 1, 1, 0, 0, 0));
    directed_rows.push_back(mk_row(psas_pkg::KIND_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(psas_pkg::KIND_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_map_readback();

    foreach (directed_rows[i]) drive_beat(directed_rows[i].b, directed_rows[i].known,
                                          directed_rows[i].rep);
    in_valid <= 1'b0;
    wall_ms = 32'd2000;

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_and_settle();
      case (p)
        0: map_word = '0;
        1: map_word = '1;
        2: map_word = 64'h0000_0605_0403_0201;
        4: map_word = {$urandom, $urandom};
        6: map_word = psas_pkg::DATA_W'(psas_pkg::MAP_RESET);
        default: begin
          map_word = '0;
          for (int i = 0; i < psas_pkg::MAP_ENTRIES; i++)
            map_word[8*i +: 8] = 8'($urandom_range(7));
        end
      endcase
      apb_access(1'b1, map_word, rd);
      model_map = map_word[psas_pkg::MAP_W-1:0];
      check_map_readback();
      case (p % 4)
        0: begin idle_pct_in = 0;  stall_pct_out = 0;  end
        1: begin idle_pct_in = 66; stall_pct_out = 0;  end
        2: begin idle_pct_in = 0;  stall_pct_out = 66; end
        default: begin idle_pct_in = 37; stall_pct_out = 37; end
      endcase
      repeat (ITEMS_PER_PHASE) drive_beat(next_random_beat(), 1'b0, no_rep);
      in_valid <= 1'b0;
    end

    drain_and_settle();
    $display("Ran %0d tick beats and %0d rate requests over %0d stream maps; %0d reports checked.",
             n_ticks, n_requests, NUM_PHASES + 1, n_reports);
    $display("Entries fired %0d times, %0d reports saw no entry enabled, %0d mismatches.",
             n_fires, n_none_enabled, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
